FILE: src/b58d_pkg.sv
// ----------------------------------------------------------------------------
// b58d_pkg
// Shared types, constants and helpers for the base58 string decoder.
// ----------------------------------------------------------------------------
package b58d_pkg;

  // Big number storage
  localparam int NUM_BYTES = 82;
  localparam int NUM_WORDS = (NUM_BYTES + 7) / 8;
  localparam int WIDX_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

  // Mask for the partly used top word (all ones when the top word is full)
  localparam logic [63:0] TOP_MASK = ((NUM_BYTES % 8) == 0) ? {64{1'b1}} :
                                     ((64'd1 << (8 * (NUM_BYTES % 8))) - 64'd1);

  // Character count and payload lengths
  localparam logic [6:0] COUNT_MAX    = 7'd127;
  localparam logic [6:0] CNT_LONG     = 7'd111;
  localparam logic [6:0] CNT_MID      = 7'd52;
  localparam logic [6:0] CNT_SHORT_LO = 7'd27;
  localparam logic [6:0] CNT_SHORT_HI = 7'd34;
  localparam logic [6:0] PAY_LONG     = 7'd78;
  localparam logic [6:0] PAY_MID      = 7'd35;
  localparam logic [6:0] PAY_SHORT    = 7'd21;
  localparam logic [6:0] CHECKSUM_LEN = 7'd4;
  localparam int         MAX_TOTAL    = 82;

  // Window index into the zero-padded number (index 0 is the pad word)
  localparam int XIDX_MAX = (NUM_WORDS > (MAX_TOTAL / 8 + 1)) ? NUM_WORDS :
                            (MAX_TOTAL / 8 + 1);
  localparam int XIDX_W   = $clog2(XIDX_MAX + 1);

  // Digit multiplier
  localparam logic [69:0] RADIX = 70'd58;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_CHAR = 2'd1,
    STATUS_BAD_LEN  = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_t;

  typedef struct packed {
    logic [63:0] data_word;
    logic [3:0]  byte_count;
    status_e     status;
    logic        last_word;
  } out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAC,
    S_CHECK,
    S_ERROR,
    S_PRELOAD,
    S_EMIT
  } ctrl_state_e;

  // Controller to datapath
  typedef struct packed {
    logic load_char;
    logic mac_step;
    logic start_emit;
    logic preload;
    logic emit_word;
    logic emit_err;
    logic clear;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_digit_ok;
    logic last;
    logic mac_last;
    logic len_ok;
    logic bad_seen;
    logic emit_last;
    logic out_ready;
  } dp_status_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] digit;
  } digit_t;

  // Map one character through the base58 alphabet
  function automatic digit_t char_to_digit(input logic [7:0] c);
    digit_t r;
    r = '0;
    if (c >= 8'h31 && c <= 8'h39) begin
      r.ok = 1'b1; r.digit = 6'(c - 8'h31);
    end else if (c >= 8'h41 && c <= 8'h48) begin
      r.ok = 1'b1; r.digit = 6'(c - 8'h41 + 8'd9);
    end else if (c >= 8'h4A && c <= 8'h4E) begin
      r.ok = 1'b1; r.digit = 6'(c - 8'h4A + 8'd17);
    end else if (c >= 8'h50 && c <= 8'h5A) begin
      r.ok = 1'b1; r.digit = 6'(c - 8'h50 + 8'd22);
    end else if (c >= 8'h61 && c <= 8'h6B) begin
      r.ok = 1'b1; r.digit = 6'(c - 8'h61 + 8'd33);
    end else if (c >= 8'h6D && c <= 8'h7A) begin
      r.ok = 1'b1; r.digit = 6'(c - 8'h6D + 8'd44);
    end
    return r;
  endfunction

  // Payload length from the character count, zero when unsupported
  function automatic logic [6:0] payload_len(input logic [6:0] cnt);
    logic [6:0] p;
    p = '0;
    if (cnt == CNT_LONG) begin
      p = PAY_LONG;
    end else if (cnt == CNT_MID) begin
      p = PAY_MID;
    end else if (cnt >= CNT_SHORT_LO && cnt <= CNT_SHORT_HI) begin
      p = PAY_SHORT;
    end
    return p;
  endfunction

endpackage

FILE: src/b58d_datapath.sv
// ----------------------------------------------------------------------------
// b58d_datapath
// Big number store, word-serial multiply-accumulate, byte window extraction
// and the output register.
// ----------------------------------------------------------------------------
module b58d_datapath (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  b58d_pkg::in_t          in_data_i,
  input  logic                   out_stall_i,
  input  b58d_pkg::dp_cmd_t      cmd_i,
  output b58d_pkg::dp_status_t   status_o,
  output logic                   out_valid_o,
  output b58d_pkg::out_t         out_data_o
);

  logic [63:0]                  bn_q [b58d_pkg::NUM_WORDS];
  logic [b58d_pkg::WIDX_W-1:0]  widx_q;
  logic [5:0]                   carry_q;
  logic [6:0]                   cnt_q;
  logic                         bad_q;
  logic                         last_q;
  logic [b58d_pkg::XIDX_W-1:0]  xi_q;
  logic [6:0]                   rem_q;
  logic [2:0]                   shift_q;
  logic [63:0]                  hi_q;
  logic                         out_valid_q;
  b58d_pkg::out_t               out_q;

  b58d_pkg::digit_t             in_dig;
  logic [6:0]                   payload;
  logic [6:0]                   total;
  logic [b58d_pkg::XIDX_W-1:0]  xm1;
  logic                         rd_hit;
  logic [b58d_pkg::WIDX_W-1:0]  rd_idx;
  logic [63:0]                  rd_word;
  logic [69:0]                  prod;
  logic [63:0]                  mac_word;
  logic [127:0]                 window;
  logic [127:0]                 shifted;
  logic                         out_ready;
  logic                         mac_last;

  assign in_dig   = b58d_pkg::char_to_digit(in_data_i.char_code);
  assign payload  = b58d_pkg::payload_len(cnt_q);
  assign total    = payload + b58d_pkg::CHECKSUM_LEN;
  assign mac_last = (widx_q == b58d_pkg::WIDX_W'(b58d_pkg::NUM_WORDS - 1));

  // Select the read word: MAC index or padded window index
  assign xm1 = xi_q - b58d_pkg::XIDX_W'(1);
  always_comb begin
    if (cmd_i.mac_step) begin
      rd_hit = 1'b1;
      rd_idx = widx_q;
    end else begin
      rd_hit = (xi_q != '0) && (xm1 < b58d_pkg::XIDX_W'(b58d_pkg::NUM_WORDS));
      rd_idx = xm1[b58d_pkg::WIDX_W-1:0];
    end
  end
  assign rd_word = rd_hit ? bn_q[rd_idx] : 64'd0;

  // Multiply one word by the radix and add the running carry
  assign prod     = {6'd0, rd_word} * b58d_pkg::RADIX + {64'd0, carry_q};
  assign mac_word = mac_last ? (prod[63:0] & b58d_pkg::TOP_MASK) : prod[63:0];

  // Extract eight bytes at the constant byte offset
  assign window  = {hi_q, rd_word};
  assign shifted = window >> {shift_q, 3'b000};

  assign out_ready = !out_valid_q || !out_stall_i;

  // Big number words
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < b58d_pkg::NUM_WORDS; i++) bn_q[i] <= '0;
    end else if (cmd_i.clear) begin
      for (int i = 0; i < b58d_pkg::NUM_WORDS; i++) bn_q[i] <= '0;
    end else if (cmd_i.mac_step) begin
      bn_q[widx_q] <= mac_word;
    end
  end

  // String state and MAC sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      widx_q  <= '0;
      carry_q <= '0;
      cnt_q   <= '0;
      bad_q   <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        cnt_q <= '0;
        bad_q <= 1'b0;
      end else if (cmd_i.load_char) begin
        widx_q  <= '0;
        carry_q <= in_dig.digit;
        last_q  <= in_data_i.last_char;
        if (cnt_q != b58d_pkg::COUNT_MAX) cnt_q <= cnt_q + 7'd1;
        if (!in_dig.ok) bad_q <= 1'b1;
      end else if (cmd_i.mac_step) begin
        widx_q  <= widx_q + b58d_pkg::WIDX_W'(1);
        carry_q <= prod[69:64];
      end
    end
  end

  // Emission window control
  always_ff @(posedge clk_i) begin
    if (cmd_i.start_emit) begin
      xi_q    <= b58d_pkg::XIDX_W'(total >> 3) + b58d_pkg::XIDX_W'(1);
      rem_q   <= total;
      shift_q <= total[2:0];
    end else if (cmd_i.preload) begin
      hi_q <= rd_word;
      xi_q <= xm1;
    end else if (cmd_i.emit_word) begin
      hi_q  <= rd_word;
      xi_q  <= xm1;
      rem_q <= rem_q - 7'd8;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_word || cmd_i.emit_err) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_word) begin
      out_q.data_word  <= shifted[63:0];
      out_q.byte_count <= (rem_q >= 7'd8) ? 4'd8 : rem_q[3:0];
      out_q.status     <= b58d_pkg::STATUS_OK;
      out_q.last_word  <= (rem_q <= 7'd8);
    end else if (cmd_i.emit_err) begin
      out_q.data_word  <= '0;
      out_q.byte_count <= '0;
      out_q.status     <= (payload == '0) ? b58d_pkg::STATUS_BAD_LEN :
                                            b58d_pkg::STATUS_BAD_CHAR;
      out_q.last_word  <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    status_o.in_digit_ok = in_dig.ok;
    status_o.last        = last_q;
    status_o.mac_last    = mac_last;
    status_o.len_ok      = (payload != '0);
    status_o.bad_seen    = bad_q;
    status_o.emit_last   = (rem_q <= 7'd8);
    status_o.out_ready   = out_ready;
  end

endmodule

FILE: src/b58d_ctrl.sv
// ----------------------------------------------------------------------------
// b58d_ctrl
// Sequencer for character intake, word-serial MAC, length check and emission.
// ----------------------------------------------------------------------------
module b58d_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  b58d_pkg::dp_status_t  status_i,
  output b58d_pkg::dp_cmd_t     cmd_o
);

  b58d_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= b58d_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      b58d_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = status_i.in_digit_ok ? b58d_pkg::S_MAC : b58d_pkg::S_CHECK;
        end
      end
      b58d_pkg::S_MAC: begin
        if (status_i.mac_last) state_d = b58d_pkg::S_CHECK;
      end
      b58d_pkg::S_CHECK: begin
        priority if (!status_i.last) begin
          state_d = b58d_pkg::S_IDLE;
        end else if (!status_i.len_ok || status_i.bad_seen) begin
          state_d = b58d_pkg::S_ERROR;
        end else begin
          state_d = b58d_pkg::S_PRELOAD;
        end
      end
      b58d_pkg::S_ERROR: begin
        if (status_i.out_ready) state_d = b58d_pkg::S_IDLE;
      end
      b58d_pkg::S_PRELOAD: begin
        state_d = b58d_pkg::S_EMIT;
      end
      b58d_pkg::S_EMIT: begin
        if (status_i.out_ready && status_i.emit_last) state_d = b58d_pkg::S_IDLE;
      end
      default: state_d = b58d_pkg::S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      b58d_pkg::S_IDLE: begin
        in_stall_o      = 1'b0;
        cmd_o.load_char = in_valid_i;
      end
      b58d_pkg::S_MAC: begin
        cmd_o.mac_step = 1'b1;
      end
      b58d_pkg::S_CHECK: begin
        cmd_o.start_emit = status_i.last && status_i.len_ok && !status_i.bad_seen;
      end
      b58d_pkg::S_ERROR: begin
        cmd_o.emit_err = status_i.out_ready;
        cmd_o.clear    = status_i.out_ready;
      end
      b58d_pkg::S_PRELOAD: begin
        cmd_o.preload = 1'b1;
      end
      b58d_pkg::S_EMIT: begin
        cmd_o.emit_word = status_i.out_ready;
        cmd_o.clear     = status_i.out_ready && status_i.emit_last;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

FILE: src/base58_string_to_bytes_decoder.sv
// ----------------------------------------------------------------------------
// base58_string_to_bytes_decoder
// Decodes base58 text (Bitcoin alphabet) one character per transaction and
// emits the payload plus checksum bytes, eight per word, most significant first.
// ----------------------------------------------------------------------------
//   channel | direction | signals                              | payload
//   in      | input     | in_valid_i, in_stall_o, in_data_i    | char_code, last_char
//   out     | output    | out_valid_o, out_stall_i, out_data_o | data_word, byte_count,
//           |           |                                      | status, last_word
//
// A valid character is taken in, then the shared 64x6 multiply-accumulate steps
// through each word of the 11-word number, and the string state is checked.
// An invalid character skips the multiply-accumulate. After the last character,
// a preload step precedes the output words; an error result is a single word.
// Reset clears the number, the count and the output valid flag. A stalled output
// register holds the sequencer; intake resumes once the last word is registered.
// ----------------------------------------------------------------------------
module base58_string_to_bytes_decoder (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  b58d_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output b58d_pkg::out_t  out_data_o
);

  b58d_pkg::dp_cmd_t    cmd;
  b58d_pkg::dp_status_t status;

  b58d_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  b58d_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the base58 string decoder. Feeds base58 text one
// character per transaction, predicts the emitted payload words (or the error
// status) from a wide-integer model of the decoder, and checks each output
// transaction field by field while both channels idle at random.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RAND_CHARS  = 250;
  localparam int NUM_BITS    = 8 * b58d_pkg::NUM_BYTES;
  localparam logic [8*58-1:0] ALPHABET =
    "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

  typedef enum int {
    TXT_CLEAN,
    TXT_BROKEN,
    TXT_NOISE
  } text_mode_e;

  typedef struct {
    logic [7:0]        code;
    int                reps;
    bit                last;
    bit                typed;
    b58d_pkg::status_e want_status;
  } dir_row_t;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           in_valid = 1'b0;
  b58d_pkg::in_t  in_data = '0;
  logic           out_stall = 1'b0;
  logic           in_stall_o;
  logic           out_valid_o;
  b58d_pkg::out_t out_data_o;

  // Decoder state as the checker sees it
  logic [NUM_BITS-1:0] num_acc = '0;
  logic [6:0]          num_count = '0;
  logic                num_bad = 1'b0;
  b58d_pkg::out_t      step_words [11];

  b58d_pkg::out_t expected_words [$];
  b58d_pkg::out_t want_word;
  int   chars_sent = 0;
  int   words_seen = 0;
  int   fail_count = 0;
  int   cycle_count = 0;
  bit   quiet_tail = 1'b0;
  bit   hold_done = 1'b0;

  // Error strings with an obvious answer are typed in; the rest is predicted
  dir_row_t dir_rows [9] = '{
    '{8'h31, 1,  1'b1, 1'b1, b58d_pkg::STATUS_BAD_LEN},  // one character right after reset
    '{8'h00, 1,  1'b1, 1'b1, b58d_pkg::STATUS_BAD_LEN},  // bad char and bad length
    '{8'hFF, 1,  1'b1, 1'b1, b58d_pkg::STATUS_BAD_LEN},
    '{8'h7A, 22, 1'b0, 1'b0, b58d_pkg::STATUS_OK},
    '{8'h30, 1,  1'b0, 1'b0, b58d_pkg::STATUS_OK},       // characters left out of the alphabet
    '{8'h49, 1,  1'b0, 1'b0, b58d_pkg::STATUS_OK},
    '{8'h4F, 1,  1'b0, 1'b0, b58d_pkg::STATUS_OK},
    '{8'h80, 1,  1'b0, 1'b0, b58d_pkg::STATUS_OK},
    '{8'h6C, 1,  1'b1, 1'b1, b58d_pkg::STATUS_BAD_CHAR}  // 27 chars with bad ones inside
  };

  base58_string_to_bytes_decoder u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_data_o  (out_data_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic int digit_of(input logic [7:0] c);
    int d;
    d = -1;
    for (int i = 0; i < 58; i++) begin
      if (ALPHABET[8*(57-i) +: 8] == c) d = i;
    end
    return d;
  endfunction

  // Advance the number by one character; on the last one fill step_words
  function automatic int decode_char(input b58d_pkg::in_t item);
    int             d;
    int             pay;
    int             total;
    int             done;
    int             cnt;
    int             pos;
    int             n;
    b58d_pkg::out_t r;
    d = digit_of(item.char_code);
    if (d < 0) begin
      num_bad = 1'b1;
    end else begin
      num_acc = num_acc * 58 + d;
    end
    if (num_count != 7'd127) num_count++;
    if (!item.last_char) return 0;

    // Payload length from the character count, zero when unsupported
    pay = 0;
    if (num_count == 7'd111) begin
      pay = 78;
    end else if (num_count == 7'd52) begin
      pay = 35;
    end else if (num_count >= 7'd27 && num_count <= 7'd34) begin
      pay = 21;
    end

    n = 0;
    if (pay == 0 || num_bad) begin
      r = '0;
      r.status = (pay == 0) ? b58d_pkg::STATUS_BAD_LEN :
                              b58d_pkg::STATUS_BAD_CHAR;
      r.last_word = 1'b1;
      step_words[0] = r;
      n = 1;
    end else begin
      // Payload plus checksum, most significant byte first, eight per word
      total = pay + 4;
      done = 0;
      while (done < total) begin
        cnt = (total - done > 8) ? 8 : total - done;
        r = '0;
        for (int b = 0; b < cnt; b++) begin
          pos = total - 1 - done - b;
          r.data_word[8*(7-b) +: 8] = (pos < b58d_pkg::NUM_BYTES) ?
                                      num_acc[8*pos +: 8] : 8'h00;
        end
        done += cnt;
        r.byte_count = 4'(cnt);
        r.status = b58d_pkg::STATUS_OK;
        r.last_word = (done == total);
        step_words[n] = r;
        n++;
      end
    end
    num_acc = '0;
    num_count = '0;
    num_bad = 1'b0;
    return n;
  endfunction

  // Offer one character, wait for the transaction, then log its results
  task automatic send_char(input b58d_pkg::in_t item, input bit typed,
                           input b58d_pkg::out_t want);
    int nres;
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    nres = decode_char(item);
    if (typed) begin
      expected_words.push_back(want);
    end else begin
      for (int k = 0; k < nres; k++) expected_words.push_back(step_words[k]);
    end
    chars_sent++;
  endtask

  task automatic send_string(input int len, input text_mode_e mode);
    b58d_pkg::in_t  item;
    b58d_pkg::out_t none;
    int             bad_pos;
    logic [7:0]     code;
    none = '0;
    bad_pos = $urandom_range(0, len - 1);
    for (int i = 0; i < len; i++) begin
      code = ALPHABET[8*$urandom_range(0, 57) +: 8];
      if (mode == TXT_NOISE && $urandom_range(0, 1) == 1) begin
        code = 8'($urandom_range(0, 255));
      end
      if (mode == TXT_BROKEN && (i == bad_pos || $urandom_range(0, 19) == 0)) begin
        do code = 8'($urandom_range(0, 255)); while (digit_of(code) >= 0);
      end
      item.char_code = code;
      item.last_char = (i == len - 1);
      send_char(item, 1'b0, none);
    end
  endtask

  // Check each output transaction against the oldest expected word
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall) begin
      if (expected_words.size() == 0) begin
        $error("unexpected output word %h", out_data_o);
        fail_count++;
      end else begin
        want_word = expected_words.pop_front();
        if (out_data_o.data_word !== want_word.data_word) begin
          $error("data_word: expected %h, got %h", want_word.data_word,
                 out_data_o.data_word);
          fail_count++;
        end
        if (out_data_o.byte_count !== want_word.byte_count) begin
          $error("byte_count: expected %0d, got %0d", want_word.byte_count,
                 out_data_o.byte_count);
          fail_count++;
        end
        if (out_data_o.status !== want_word.status) begin
          $error("status: expected %0d, got %0d", want_word.status, out_data_o.status);
          fail_count++;
        end
        if (out_data_o.last_word !== want_word.last_word) begin
          $error("last_word: expected %0d, got %0d", want_word.last_word,
                 out_data_o.last_word);
          fail_count++;
        end
      end
      words_seen++;
    end
  end

  // Stall the output in bursts, once for a long stretch to back up the input
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!hold_done && words_seen >= 12) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (400) @(posedge clk_i);
        out_stall <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
        out_stall <= 1'b0;
      end
    end
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    b58d_pkg::in_t  item;
    b58d_pkg::out_t want;
    int             pick;
    int             rand_start;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table
    foreach (dir_rows[r]) begin
      for (int k = 0; k < dir_rows[r].reps; k++) begin
        item.char_code = dir_rows[r].code;
        item.last_char = dir_rows[r].last && (k == dir_rows[r].reps - 1);
        want = '0;
        want.status = dir_rows[r].want_status;
        want.last_word = 1'b1;
        send_char(item, dir_rows[r].typed && item.last_char, want);
      end
    end
    // Largest number a 27-character string can hold
    for (int k = 0; k < 27; k++) begin
      item.char_code = 8'h7A;
      item.last_char = (k == 26);
      send_char(item, 1'b0, want);
    end

    // Hold the sender until the block has drained
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);

    // Random strings, mostly well formed
    rand_start = chars_sent;
    while (chars_sent - rand_start < RAND_CHARS) begin
      if (chars_sent - rand_start >= RAND_CHARS - 50) quiet_tail = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        send_string($urandom_range(27, 34), TXT_CLEAN);
      end else if (pick < 63) begin
        send_string(52, TXT_CLEAN);
      end else if (pick < 67) begin
        send_string(111, TXT_CLEAN);
      end else if (pick < 77) begin
        send_string(($urandom_range(0, 3) == 0) ? 52 : $urandom_range(27, 34), TXT_BROKEN);
      end else begin
        send_string(($urandom_range(0, 4) == 0) ? $urandom_range(100, 130) :
                    $urandom_range(1, 12), TXT_NOISE);
      end
    end

    // Drain and settle
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
